/* rtl/core/tvp_pkg.sv */
// trapezoid velocity profile: shared types, widths and constants
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package tvp_pkg;

  localparam int unsigned SPD_W    = 20;
  localparam int unsigned ACC_W    = 27;
  localparam int unsigned LEN_W    = 22;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SQ_W     = 2 * SPD_W;          // speed squared
  localparam int unsigned PROD_W   = ACC_W + LEN_W;      // accel times length
  localparam int unsigned VSQ_W    = 50;                 // squared peak speed
  localparam int unsigned ROOT_W   = VSQ_W / 2;
  localparam int unsigned DIV_NW   = 62;                 // divider dividend and quotient
  localparam int unsigned DIV_DW   = ACC_W + 1;          // divider divisor
  localparam int unsigned DIV_LAT  = DIV_NW;
  localparam int unsigned SQRT_LAT = ROOT_W;

  localparam logic [SPD_W-1:0]  US_PER_S  = 20'd1000000;
  localparam logic [SPD_W-1:0]  SPEED_MAX = '1;
  localparam logic [LEN_W-1:0]  DIST_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  typedef enum logic {
    PROF_CRUISE   = 1'b0,
    PROF_TRIANGLE = 1'b1
  } profile_e;

  typedef struct packed {
    logic [SPD_W-1:0] requested_speed;
    logic [SPD_W-1:0] start_speed;
    logic [SPD_W-1:0] end_speed;
    logic [ACC_W-1:0] accel_rate;
    logic [LEN_W-1:0] move_length;
  } tvp_in_t;

  typedef struct packed {
    logic [LEN_W-1:0]  accel_distance;
    logic [LEN_W-1:0]  decel_distance;
    logic [SPD_W-1:0]  top_speed;
    profile_e          profile_kind;
    logic [TIME_W-1:0] move_time;
  } tvp_out_t;

  // result fields settled before the time division
  typedef struct packed {
    logic [LEN_W-1:0] accel_distance;
    logic [LEN_W-1:0] decel_distance;
    logic [SPD_W-1:0] top_speed;
    profile_e         profile_kind;
  } tvp_res_t;

  typedef struct packed {
    tvp_in_t           mv;
    logic              sgn_ad;
    logic              sgn_dd;
    logic              sgn_a2;
    logic [ROOT_W-1:0] root;
  } tvp_side1_t;

  typedef struct packed {
    tvp_res_t res;
    logic     sgn_t1;
    logic     sgn_t3;
    logic     top_zero;
  } tvp_side2_t;

endpackage

/* rtl/core/trapezoid_velocity_profile_unit.sv */
// top level of the trapezoid velocity profile block
// depends on tvp_pkg, tvp_div and tvp_isqrt
`timescale 1ns / 1ps

// Takes one planned move per clock and returns its accel and decel distances,
// peak speed, profile kind and total time, one result per move, in order.
// The pipeline has six front stages for squares and products, a
// 62-stage bit-per-cycle divider bank (with the 25-stage square root beside
// it), seven stages of profile selection and time numerators, a second
// 62-stage divider bank for the time terms and three stages to sum and
// saturate. A new item is taken every cycle; the whole pipeline holds only
// while a finished result sits at the output and is stalled.

module trapezoid_velocity_profile_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tvp_pkg::tvp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tvp_pkg::tvp_out_t out_data_o
);
  import tvp_pkg::*;

  function automatic logic [LEN_W-1:0] clamp_dist(logic signed [41:0] x);
    logic [LEN_W-1:0] r;
    if (x[41]) r = '0;
    else if (x[40:LEN_W] != '0) r = DIST_MAX;
    else r = x[LEN_W-1:0];
    return r;
  endfunction

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // valid bits for every stage
  logic [5:0]         fv_q;
  logic [DIV_LAT-1:0] bv1_q;
  logic [6:0]         ev_q;
  logic [DIV_LAT-1:0] bv2_q;
  logic [2:0]         tv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q  <= '0;
      bv1_q <= '0;
      ev_q  <= '0;
      bv2_q <= '0;
      tv_q  <= '0;
    end else if (en) begin
      fv_q  <= {fv_q[4:0], in_valid_i};
      bv1_q <= {bv1_q[DIV_LAT-2:0], fv_q[5]};
      ev_q  <= {ev_q[5:0], bv1_q[DIV_LAT-1]};
      bv2_q <= {bv2_q[DIV_LAT-2:0], ev_q[6]};
      tv_q  <= {tv_q[1:0], bv2_q[DIV_LAT-1]};
    end
  end

  // ---------------- front stages ----------------
  tvp_in_t s1_mv_q, s2_mv_q, s3_mv_q, s4_mv_q, s5_mv_q, s6_mv_q;
  logic [SQ_W-1:0]   s2_r2_q, s2_u2_q, s2_w2_q, s3_u2_q, s4_u2_q;
  logic [PROD_W-1:0] s2_ad_q, s3_ad_q;
  logic signed [SQ_W:0] s3_nad_q, s3_ndd_q;
  logic [SQ_W-1:0]   s3_hs_q;
  logic [SQ_W:0]     s4_mad_q, s4_mdd_q, s5_mad_q, s5_mdd_q, s6_mad_q, s6_mdd_q;
  logic              s4_sad_q, s4_sdd_q, s5_sad_q, s5_sdd_q, s6_sad_q, s6_sdd_q;
  logic [VSQ_W-1:0]  s4_vsq_q, s5_vsq_q, s6_vsq_q;
  logic signed [VSQ_W:0] s5_n2_q;
  logic [VSQ_W:0]    s6_m2_q;
  logic              s6_s2_q;

  logic signed [SQ_W:0]  neg_nad, neg_ndd;
  logic signed [VSQ_W:0] neg_n2;
  assign neg_nad = -s3_nad_q;
  assign neg_ndd = -s3_ndd_q;
  assign neg_n2  = -s5_n2_q;

  // zero acceleration acts as one
  tvp_in_t in_mv;
  always_comb begin
    in_mv = in_data_i;
    if (in_data_i.accel_rate == '0) in_mv.accel_rate = ACC_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mv_q <= in_mv;

      s2_mv_q <= s1_mv_q;
      s2_r2_q <= SQ_W'(s1_mv_q.requested_speed) * SQ_W'(s1_mv_q.requested_speed);
      s2_u2_q <= SQ_W'(s1_mv_q.start_speed) * SQ_W'(s1_mv_q.start_speed);
      s2_w2_q <= SQ_W'(s1_mv_q.end_speed) * SQ_W'(s1_mv_q.end_speed);
      s2_ad_q <= PROD_W'(s1_mv_q.accel_rate) * PROD_W'(s1_mv_q.move_length);

      s3_mv_q  <= s2_mv_q;
      s3_nad_q <= $signed({1'b0, s2_r2_q}) - $signed({1'b0, s2_u2_q});
      s3_ndd_q <= $signed({1'b0, s2_r2_q}) - $signed({1'b0, s2_w2_q});
      s3_hs_q  <= SQ_W'(({1'b0, s2_u2_q} + {1'b0, s2_w2_q}) >> 1);
      s3_ad_q  <= s2_ad_q;
      s3_u2_q  <= s2_u2_q;

      s4_mv_q  <= s3_mv_q;
      s4_sad_q <= s3_nad_q[SQ_W];
      s4_sdd_q <= s3_ndd_q[SQ_W];
      s4_mad_q <= s3_nad_q[SQ_W] ? neg_nad : s3_nad_q;
      s4_mdd_q <= s3_ndd_q[SQ_W] ? neg_ndd : s3_ndd_q;
      s4_vsq_q <= VSQ_W'(s3_ad_q) + VSQ_W'(s3_hs_q);
      s4_u2_q  <= s3_u2_q;

      s5_mv_q  <= s4_mv_q;
      s5_n2_q  <= $signed({1'b0, s4_vsq_q}) - $signed({(VSQ_W + 1 - SQ_W)'(0), s4_u2_q});
      s5_mad_q <= s4_mad_q;
      s5_mdd_q <= s4_mdd_q;
      s5_sad_q <= s4_sad_q;
      s5_sdd_q <= s4_sdd_q;
      s5_vsq_q <= s4_vsq_q;

      s6_mv_q  <= s5_mv_q;
      s6_s2_q  <= s5_n2_q[VSQ_W];
      s6_m2_q  <= s5_n2_q[VSQ_W] ? neg_n2 : s5_n2_q;
      s6_mad_q <= s5_mad_q;
      s6_mdd_q <= s5_mdd_q;
      s6_sad_q <= s5_sad_q;
      s6_sdd_q <= s5_sdd_q;
      s6_vsq_q <= s5_vsq_q;
    end
  end

  // ---------------- first divider bank and square root ----------------
  logic [DIV_DW-1:0] two_a;
  logic [DIV_NW-1:0] q_ad, q_dd, q_a2;
  logic [ROOT_W-1:0] sq_root;
  assign two_a = {s6_mv_q.accel_rate, 1'b0};

  tvp_div u_div_ad (.clk_i, .en_i(en), .num_i(DIV_NW'(s6_mad_q)), .den_i(two_a), .quo_o(q_ad));
  tvp_div u_div_dd (.clk_i, .en_i(en), .num_i(DIV_NW'(s6_mdd_q)), .den_i(two_a), .quo_o(q_dd));
  tvp_div u_div_a2 (.clk_i, .en_i(en), .num_i(DIV_NW'(s6_m2_q)), .den_i(two_a), .quo_o(q_a2));
  tvp_isqrt u_sqrt (.clk_i, .en_i(en), .x_i(s6_vsq_q), .root_o(sq_root));

  tvp_side1_t sd1_q [DIV_LAT];
  tvp_side1_t sd1_in;
  tvp_side1_t b1;

  always_comb begin
    sd1_in.mv     = s6_mv_q;
    sd1_in.sgn_ad = s6_sad_q;
    sd1_in.sgn_dd = s6_sdd_q;
    sd1_in.sgn_a2 = s6_s2_q;
    sd1_in.root   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd1_q[0] <= sd1_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        if (k == SQRT_LAT) begin
          // root leaves the square root unit level with this stage
          sd1_q[k] <= '{mv: sd1_q[k-1].mv, sgn_ad: sd1_q[k-1].sgn_ad,
                        sgn_dd: sd1_q[k-1].sgn_dd, sgn_a2: sd1_q[k-1].sgn_a2,
                        root: sq_root};
        end else begin
          sd1_q[k] <= sd1_q[k-1];
        end
      end
    end
  end

  assign b1 = sd1_q[DIV_LAT-1];

  // ---------------- profile selection ----------------
  tvp_in_t e1_mv_q, e2_mv_q, e3_mv_q;
  logic signed [41:0] e1_ad_q, e1_dd_q, e2_ad_q, e2_dd_q, e3_adf_q, e3_ddf_q;
  logic signed [51:0] e1_a2_q;
  logic [ROOT_W-1:0]  e1_root_q, e2_root_q, e3_top_q;
  logic               e2_tri_q;
  logic [LEN_W-1:0]   e2_ac_q;
  profile_e           e3_kind_q;

  logic signed [41:0] ad0_mag, dd0_mag;
  logic signed [51:0] a2_mag;
  assign ad0_mag = $signed({1'b0, q_ad[40:0]});
  assign dd0_mag = $signed({1'b0, q_dd[40:0]});
  assign a2_mag  = $signed({1'b0, q_a2[50:0]});

  logic signed [42:0] dist_sum;
  logic signed [42:0] len43;
  logic               a2_big;
  assign dist_sum = $signed({e1_ad_q[41], e1_ad_q}) + $signed({e1_dd_q[41], e1_dd_q});
  assign len43    = $signed({21'd0, e1_mv_q.move_length});
  assign a2_big   = e1_a2_q > $signed({30'd0, e1_mv_q.move_length});

  // time numerator parts
  logic signed [25:0] e4_e1_q, e4_e3_q;
  logic signed [42:0] e4_e2_q;
  tvp_res_t           e4_res_q, e5_res_q, e6_res_q, e7_res_q;
  logic               e4_tz_q, e5_tz_q, e6_tz_q, e7_tz_q;
  logic [ACC_W-1:0]   e4_a_q, e5_a_q, e6_a_q, e7_a_q;
  logic [ROOT_W-1:0]  e4_top_q, e5_top_q, e6_top_q, e7_top_q;
  logic [ROOT_W-1:0]  e5_m1_q, e5_m3_q;
  logic               e5_s1_q, e5_s3_q, e6_s1_q, e6_s3_q, e7_s1_q, e7_s3_q;
  logic [40:0]        e5_e2_q;
  logic [44:0]        e6_p1_q, e6_p3_q, e7_p1_q, e7_p3_q;
  logic [40:0]        e6_plo_q;
  logic [39:0]        e6_phi_q;
  logic [60:0]        e7_p2_q;

  logic signed [25:0] neg_e1, neg_e3;
  assign neg_e1 = -e4_e1_q;
  assign neg_e3 = -e4_e3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_mv_q   <= b1.mv;
      e1_root_q <= b1.root;
      e1_ad_q   <= b1.sgn_ad ? -ad0_mag : ad0_mag;
      e1_dd_q   <= b1.sgn_dd ? -dd0_mag : dd0_mag;
      e1_a2_q   <= b1.sgn_a2 ? -a2_mag : a2_mag;

      e2_mv_q   <= e1_mv_q;
      e2_root_q <= e1_root_q;
      e2_ad_q   <= e1_ad_q;
      e2_dd_q   <= e1_dd_q;
      e2_tri_q  <= (dist_sum >= len43);
      // accel distance of a triangle held within the move length
      if (e1_a2_q[51]) e2_ac_q <= '0;
      else if (a2_big) e2_ac_q <= e1_mv_q.move_length;
      else e2_ac_q <= e1_a2_q[LEN_W-1:0];

      e3_mv_q <= e2_mv_q;
      if (e2_tri_q) begin
        e3_kind_q <= PROF_TRIANGLE;
        e3_top_q  <= e2_root_q;
        e3_adf_q  <= $signed({20'd0, e2_ac_q});
        e3_ddf_q  <= $signed({20'd0, e2_mv_q.move_length - e2_ac_q});
      end else begin
        e3_kind_q <= PROF_CRUISE;
        e3_top_q  <= ROOT_W'(e2_mv_q.requested_speed);
        e3_adf_q  <= e2_ad_q;
        e3_ddf_q  <= e2_dd_q;
      end

      e4_e1_q <= $signed({1'b0, e3_top_q}) - $signed({6'd0, e3_mv_q.start_speed});
      e4_e3_q <= $signed({1'b0, e3_top_q}) - $signed({6'd0, e3_mv_q.end_speed});
      e4_e2_q <= $signed({21'd0, e3_mv_q.move_length}) - $signed({e3_adf_q[41], e3_adf_q})
                 - $signed({e3_ddf_q[41], e3_ddf_q});
      e4_res_q.accel_distance <= clamp_dist(e3_adf_q);
      e4_res_q.decel_distance <= clamp_dist(e3_ddf_q);
      e4_res_q.top_speed      <= (e3_top_q[ROOT_W-1:SPD_W] != '0) ? SPEED_MAX
                                                                  : e3_top_q[SPD_W-1:0];
      e4_res_q.profile_kind   <= e3_kind_q;
      e4_tz_q  <= (e3_top_q == '0);
      e4_a_q   <= e3_mv_q.accel_rate;
      e4_top_q <= e3_top_q;

      // cruise distance is never negative here
      e5_s1_q  <= e4_e1_q[25];
      e5_s3_q  <= e4_e3_q[25];
      e5_m1_q  <= e4_e1_q[25] ? neg_e1[ROOT_W-1:0] : e4_e1_q[ROOT_W-1:0];
      e5_m3_q  <= e4_e3_q[25] ? neg_e3[ROOT_W-1:0] : e4_e3_q[ROOT_W-1:0];
      e5_e2_q  <= e4_e2_q[40:0];
      e5_res_q <= e4_res_q;
      e5_tz_q  <= e4_tz_q;
      e5_a_q   <= e4_a_q;
      e5_top_q <= e4_top_q;

      e6_p1_q  <= 45'(e5_m1_q) * 45'(US_PER_S);
      e6_p3_q  <= 45'(e5_m3_q) * 45'(US_PER_S);
      e6_plo_q <= 41'(e5_e2_q[20:0]) * 41'(US_PER_S);
      e6_phi_q <= 40'(e5_e2_q[40:21]) * 40'(US_PER_S);
      e6_s1_q  <= e5_s1_q;
      e6_s3_q  <= e5_s3_q;
      e6_res_q <= e5_res_q;
      e6_tz_q  <= e5_tz_q;
      e6_a_q   <= e5_a_q;
      e6_top_q <= e5_top_q;

      e7_p2_q  <= (61'(e6_phi_q) << 21) + 61'(e6_plo_q);
      e7_p1_q  <= e6_p1_q;
      e7_p3_q  <= e6_p3_q;
      e7_s1_q  <= e6_s1_q;
      e7_s3_q  <= e6_s3_q;
      e7_res_q <= e6_res_q;
      e7_tz_q  <= e6_tz_q;
      e7_a_q   <= e6_a_q;
      e7_top_q <= e6_top_q;
    end
  end

  // ---------------- time divider bank ----------------
  logic [DIV_NW-1:0] q_t1, q_t2, q_t3;

  tvp_div u_div_t1 (.clk_i, .en_i(en), .num_i(DIV_NW'(e7_p1_q)), .den_i(DIV_DW'(e7_a_q)),
                    .quo_o(q_t1));
  tvp_div u_div_t3 (.clk_i, .en_i(en), .num_i(DIV_NW'(e7_p3_q)), .den_i(DIV_DW'(e7_a_q)),
                    .quo_o(q_t3));
  tvp_div u_div_t2 (.clk_i, .en_i(en), .num_i(DIV_NW'(e7_p2_q)), .den_i(DIV_DW'(e7_top_q)),
                    .quo_o(q_t2));

  tvp_side2_t sd2_q [DIV_LAT];
  tvp_side2_t sd2_in;
  tvp_side2_t b2;

  always_comb begin
    sd2_in.res      = e7_res_q;
    sd2_in.sgn_t1   = e7_s1_q;
    sd2_in.sgn_t3   = e7_s3_q;
    sd2_in.top_zero = e7_tz_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd2_q[0] <= sd2_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd2_q[k] <= sd2_q[k-1];
      end
    end
  end

  assign b2 = sd2_q[DIV_LAT-1];

  // ---------------- time sum and output ----------------
  logic signed [46:0] f1_t1_q, f1_t3_q;
  logic [60:0]        f1_q2_q, f2_q2_q;
  tvp_res_t           f1_res_q, f2_res_q;
  logic               f1_tz_q, f2_tz_q;
  logic signed [47:0] f2_s13_q;
  tvp_out_t           out_q;

  logic signed [46:0] t1_mag, t3_mag;
  logic signed [63:0] t_sum;
  assign t1_mag = $signed({2'b00, q_t1[44:0]});
  assign t3_mag = $signed({2'b00, q_t3[44:0]});
  assign t_sum  = $signed({{16{f2_s13_q[47]}}, f2_s13_q}) + $signed({3'b000, f2_q2_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_t1_q  <= b2.sgn_t1 ? -t1_mag : t1_mag;
      f1_t3_q  <= b2.sgn_t3 ? -t3_mag : t3_mag;
      f1_q2_q  <= q_t2[60:0];
      f1_res_q <= b2.res;
      f1_tz_q  <= b2.top_zero;

      f2_s13_q <= $signed({f1_t1_q[46], f1_t1_q}) + $signed({f1_t3_q[46], f1_t3_q});
      f2_q2_q  <= f1_q2_q;
      f2_res_q <= f1_res_q;
      f2_tz_q  <= f1_tz_q;

      out_q.accel_distance <= f2_res_q.accel_distance;
      out_q.decel_distance <= f2_res_q.decel_distance;
      out_q.top_speed      <= f2_res_q.top_speed;
      out_q.profile_kind   <= f2_res_q.profile_kind;
      if (f2_tz_q || t_sum[63]) out_q.move_time <= '0;
      else if (t_sum[62:TIME_W] != '0) out_q.move_time <= TIME_MAX;
      else out_q.move_time <= t_sum[TIME_W-1:0];
    end
  end

  assign out_valid_o = tv_q[2];
  assign out_data_o  = out_q;

endmodule

/* rtl/core/tvp_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on tvp_pkg for widths
`timescale 1ns / 1ps

module tvp_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tvp_pkg::DIV_NW-1:0] num_i,
  input  logic [tvp_pkg::DIV_DW-1:0] den_i,
  output logic [tvp_pkg::DIV_NW-1:0] quo_o
);
  import tvp_pkg::*;

  logic [DIV_NW-1:0] n_q [DIV_NW];
  logic [DIV_DW-1:0] r_q [DIV_NW-1];
  logic [DIV_DW-1:0] d_q [DIV_NW-1];

  logic [DIV_NW-1:0] n_in [DIV_NW];
  logic [DIV_DW-1:0] r_in [DIV_NW];
  logic [DIV_DW-1:0] d_in [DIV_NW];
  logic [DIV_NW-1:0] n_d  [DIV_NW];
  logic [DIV_DW-1:0] r_d  [DIV_NW];

  always_comb begin
    n_in[0] = num_i;
    r_in[0] = '0;
    d_in[0] = den_i;
    for (int k = 1; k < DIV_NW; k++) begin
      n_in[k] = n_q[k-1];
      r_in[k] = r_q[k-1];
      d_in[k] = d_q[k-1];
    end
  end

  // quotient bits shift in at the bottom of the dividend word
  always_comb begin
    logic [DIV_DW:0] t;
    logic [DIV_DW:0] diff;
    logic            ge;
    for (int k = 0; k < DIV_NW; k++) begin
      t       = {r_in[k], n_in[k][DIV_NW-1]};
      diff    = t - {1'b0, d_in[k]};
      ge      = (t >= {1'b0, d_in[k]});
      n_d[k]  = {n_in[k][DIV_NW-2:0], ge};
      r_d[k]  = ge ? diff[DIV_DW-1:0] : t[DIV_DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_NW; k++) begin
        n_q[k] <= n_d[k];
      end
      for (int k = 0; k < DIV_NW - 1; k++) begin
        r_q[k] <= r_d[k];
        d_q[k] <= d_in[k];
      end
    end
  end

  assign quo_o = n_q[DIV_NW-1];

endmodule

/* rtl/core/tvp_isqrt.sv */
// pipelined integer square root, one root bit per stage
// depends on tvp_pkg for widths
`timescale 1ns / 1ps

module tvp_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tvp_pkg::VSQ_W-1:0]  x_i,
  output logic [tvp_pkg::ROOT_W-1:0] root_o
);
  import tvp_pkg::*;

  localparam int unsigned RW = ROOT_W + 2;

  logic [VSQ_W-1:0]  x_q    [SQRT_LAT-1];
  logic [RW-1:0]     rem_q  [SQRT_LAT-1];
  logic [ROOT_W-1:0] root_q [SQRT_LAT];

  logic [VSQ_W-1:0]  x_in    [SQRT_LAT];
  logic [RW-1:0]     rem_in  [SQRT_LAT];
  logic [ROOT_W-1:0] root_in [SQRT_LAT];
  logic [VSQ_W-1:0]  x_d     [SQRT_LAT];
  logic [RW-1:0]     rem_d   [SQRT_LAT];
  logic [ROOT_W-1:0] root_d  [SQRT_LAT];

  always_comb begin
    x_in[0]    = x_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int k = 1; k < SQRT_LAT; k++) begin
      x_in[k]    = x_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
    end
  end

  // bring down two bits, try root*4+1 against the partial remainder
  always_comb begin
    logic [RW+1:0] rp;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;
    for (int k = 0; k < SQRT_LAT; k++) begin
      rp        = {rem_in[k], x_in[k][VSQ_W-1 -: 2]};
      trial     = {2'b00, root_in[k], 2'b01};
      diff      = rp - trial;
      ge        = (rp >= trial);
      rem_d[k]  = ge ? diff[RW-1:0] : rp[RW-1:0];
      root_d[k] = {root_in[k][ROOT_W-2:0], ge};
      x_d[k]    = {x_in[k][VSQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        root_q[k] <= root_d[k];
      end
      for (int k = 0; k < SQRT_LAT - 1; k++) begin
        rem_q[k] <= rem_d[k];
        x_q[k]   <= x_d[k];
      end
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule

/* rtl/core/tvp_checker.sv */
// port-level checks for the trapezoid velocity profile block
// depends on tvp_pkg, bound to trapezoid_velocity_profile_unit
`timescale 1ns / 1ps

module tvp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tvp_pkg::tvp_out_t out_data_o
);
  import tvp_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // input side freezes exactly when the output is held
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output hold");

  a_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.top_speed == '0) |-> (out_data_o.move_time == '0))
    else $error("nonzero time with zero top speed");

endmodule

bind trapezoid_velocity_profile_unit tvp_checker u_tvp_checker (.*);
